// ===== hdl/hamming74_soft_decision_decoder_macros.svh =====
// Assertion helpers used by the decoder.
`ifndef HAMMING74_SOFT_DECISION_DECODER_MACROS_SVH
`define HAMMING74_SOFT_DECISION_DECODER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define HSD_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define HSD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/hsd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package hsd_pkg;

    localparam int SOFT_W   = 8;
    localparam int NUM_BITS = 7;
    localparam int SYM_W    = 4;
    localparam int NUM_SYM  = 1 << SYM_W;
    localparam int COST_W   = 11;
    localparam int BYTE_W   = 8;
    localparam int GROUP_N  = 4;
    localparam int NUM_GRP  = NUM_SYM / GROUP_N;

    localparam logic [NUM_BITS-1:0] GEN_D3 = 7'h70;
    localparam logic [NUM_BITS-1:0] GEN_D2 = 7'h4c;
    localparam logic [NUM_BITS-1:0] GEN_D1 = 7'h2a;
    localparam logic [NUM_BITS-1:0] GEN_D0 = 7'h69;

    typedef struct packed {
        logic [COST_W-1:0] cost;
        logic [SYM_W-1:0]  sym;
    } t_cand;

    function automatic logic [NUM_BITS-1:0] codeword_of(input logic [SYM_W-1:0] sym);
        logic [NUM_BITS-1:0] c;
        c = '0;
        if (sym[3]) c = c ^ GEN_D3;
        if (sym[2]) c = c ^ GEN_D2;
        if (sym[1]) c = c ^ GEN_D1;
        if (sym[0]) c = c ^ GEN_D0;
        return c;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/hsd_lane.sv =====
`timescale 1ns / 1ps
`default_nettype none

module hsd_lane (
    input  logic                                             i_clk,
    input  logic                                             i_en,
    input  logic [hsd_pkg::NUM_BITS-1:0]                     i_codeword,
    input  logic [hsd_pkg::NUM_BITS-1:0][hsd_pkg::SOFT_W-1:0] i_soft,
    output logic [hsd_pkg::COST_W-1:0]                       o_cost
);
    import hsd_pkg::*;

    logic [COST_W-1:0] n_cost;
    logic [COST_W-1:0] r_cost;

    // soft j weighs against codeword bit NUM_BITS-1-j
    always_comb begin
        n_cost = '0;
        for (int j = 0; j < NUM_BITS; j++) begin
            n_cost = n_cost + COST_W'(i_soft[j] ^ {SOFT_W{i_codeword[NUM_BITS-1-j]}});
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_cost <= n_cost;
        end
    end

    assign o_cost = r_cost;

endmodule

`default_nettype wire

// ===== hdl/hsd_min4.sv =====
`timescale 1ns / 1ps
`default_nettype none

module hsd_min4 (
    input  hsd_pkg::t_cand [hsd_pkg::GROUP_N-1:0] i_cand,
    output hsd_pkg::t_cand                        o_best
);
    import hsd_pkg::*;

    t_cand w_lo;
    t_cand w_hi;

    // on a tie keep the lower symbol
    always_comb begin
        w_lo   = (i_cand[1].cost < i_cand[0].cost) ? i_cand[1] : i_cand[0];
        w_hi   = (i_cand[3].cost < i_cand[2].cost) ? i_cand[3] : i_cand[2];
        o_best = (w_hi.cost < w_lo.cost) ? w_hi : w_lo;
    end

endmodule

`default_nettype wire

// ===== hdl/hamming74_soft_decision_decoder.sv =====
// Hamming(7,4) soft-decision maximum-likelihood decoder. Each transfer on the
// slave side carries one received codeword as seven 8-bit soft values (0 is a
// strong zero, 255 a strong one) plus tlast for the last codeword of a
// message. Sixteen lanes score all codewords in parallel, a registered
// minimum tree picks the cheapest symbol (lower symbol on a tie), and symbols
// are paired into bytes, first symbol in the high nibble. A message with an
// odd codeword count ends in a byte whose low nibble is zero. The block takes
// one codeword every cycle while tready is high; the transfer that completes
// a byte passes the lane register, then the tree register, before the byte is
// loaded into the output register. tready drops only when the lane stage, the
// tree stage and the output register are all full and the master side stalls.
`timescale 1ns / 1ps
`default_nettype none
`include "hamming74_soft_decision_decoder_macros.svh"

module hamming74_soft_decision_decoder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [55:0] s_axis_tdata,  // soft_bit_0, soft_bit_1, .. soft_bit_6
    input  logic        s_axis_tlast,  // final_codeword
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,  // decoded_byte
    output logic        m_axis_tlast   // final_byte
);
    import hsd_pkg::*;

    logic [NUM_BITS-1:0][SOFT_W-1:0] w_soft;
    logic [COST_W-1:0]               w_cost [NUM_SYM];
    t_cand [GROUP_N-1:0]             w_grp_in [NUM_GRP];
    t_cand                           w_grp_best [NUM_GRP];
    t_cand [NUM_GRP-1:0]             r_grp;
    t_cand                           w_best;

    logic w_en1;
    logic w_rdy2;
    logic w_rdy3;
    logic w_fire3;
    logic w_emit;

    logic r_v1, n_v1, r_fin1;
    logic r_v2, n_v2, r_fin2;
    logic r_pending, n_pending;
    logic [SYM_W-1:0]  r_held, n_held;
    logic r_ov, n_ov;
    logic [BYTE_W-1:0] r_byte, n_byte;
    logic r_last, n_last;

    assign w_soft        = s_axis_tdata;
    assign w_rdy3        = !r_ov || m_axis_tready;
    assign w_rdy2        = !r_v2 || w_rdy3;
    assign s_axis_tready = !r_v1 || w_rdy2;
    assign w_en1         = s_axis_tvalid && s_axis_tready;
    assign w_fire3       = r_v2 && w_rdy3;

    for (genvar s = 0; s < NUM_SYM; s++) begin : g_lane
        hsd_lane u_lane (
            .i_clk      (i_clk),
            .i_en       (w_en1),
            .i_codeword (codeword_of(SYM_W'(s))),
            .i_soft     (w_soft),
            .o_cost     (w_cost[s])
        );
    end

    for (genvar g = 0; g < NUM_GRP; g++) begin : g_grp
        for (genvar k = 0; k < GROUP_N; k++) begin : g_in
            assign w_grp_in[g][k].cost = w_cost[g*GROUP_N+k];
            assign w_grp_in[g][k].sym  = SYM_W'(g*GROUP_N+k);
        end
        hsd_min4 u_min (
            .i_cand (w_grp_in[g]),
            .o_best (w_grp_best[g])
        );
    end

    hsd_min4 u_final (
        .i_cand (r_grp),
        .o_best (w_best)
    );

    always_comb begin
        n_v1      = s_axis_tready ? s_axis_tvalid : r_v1;
        n_v2      = w_rdy2 ? r_v1 : r_v2;
        n_pending = r_pending;
        n_held    = r_held;
        n_ov      = r_ov && !m_axis_tready;
        n_byte    = r_byte;
        n_last    = r_last;
        w_emit    = 1'b0;
        if (w_fire3) begin
            if (r_pending) begin
                w_emit    = 1'b1;
                n_byte    = {r_held, w_best.sym};
                n_last    = r_fin2;
                n_pending = 1'b0;
                n_held    = '0;
            end else if (r_fin2) begin
                w_emit = 1'b1;
                n_byte = {w_best.sym, SYM_W'(0)};
                n_last = 1'b1;
                n_held = '0;
            end else begin
                n_held    = w_best.sym;
                n_pending = 1'b1;
            end
        end
        if (w_emit) begin
            n_ov = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1      <= 1'b0;
            r_v2      <= 1'b0;
            r_pending <= 1'b0;
            r_held    <= '0;
            r_ov      <= 1'b0;
        end else begin
            r_v1      <= n_v1;
            r_v2      <= n_v2;
            r_pending <= n_pending;
            r_held    <= n_held;
            r_ov      <= n_ov;
        end
        if (w_en1) begin
            r_fin1 <= s_axis_tlast;
        end
        if (r_v1 && w_rdy2) begin
            r_fin2 <= r_fin1;
            for (int g = 0; g < NUM_GRP; g++) begin
                r_grp[g] <= w_grp_best[g];
            end
        end
        r_byte <= n_byte;
        r_last <= n_last;
    end

    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata  = r_byte;
    assign m_axis_tlast  = r_last;

    `HSD_ASSERT_NEXT(a_accept_fills, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready, r_v1, "accepted codeword lost before lane stage")
    `HSD_ASSERT_NEXT(a_pair_closes, i_clk, i_rst_n, w_fire3 && r_pending, !r_pending && r_ov, "second symbol did not close the byte")
    `HSD_ASSERT_NEXT(a_first_held, i_clk, i_rst_n, w_fire3 && !r_pending && !r_fin2, r_pending, "first symbol of a pair not held")

endmodule

`default_nettype wire

// ===== bench/hsd_checker.sv =====
`timescale 1ns / 1ps

module hsd_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [55:0] i_s_tdata,   // soft_bit_0, soft_bit_1, .. soft_bit_6
    input  logic        i_s_tlast,   // final_codeword
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [7:0]  i_m_tdata,   // decoded_byte
    input  logic        i_m_tlast,   // final_byte
    output int          o_fail_count,
    output int          o_pending
);

    typedef struct packed {
        logic [7:0] dec_byte;
        logic       final_byte;
    } t_byte_exp;

    t_byte_exp  byte_q[$];
    logic [3:0] first_nibble;
    logic       have_nibble;
    int         fail_total;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    function automatic logic [3:0] ml_symbol(input logic [55:0] soft_word);
        logic [6:0]  cw;
        logic [10:0] cost;
        logic [10:0] best_cost;
        logic [3:0]  best;
        logic [3:0]  cand;
        logic [7:0]  s;
        best      = '0;
        best_cost = '0;
        for (int k = 0; k < 16; k++) begin
            cand = k[3:0];
            cw   = '0;
            if (cand[3]) cw = cw ^ hsd_pkg::GEN_D3;
            if (cand[2]) cw = cw ^ hsd_pkg::GEN_D2;
            if (cand[1]) cw = cw ^ hsd_pkg::GEN_D1;
            if (cand[0]) cw = cw ^ hsd_pkg::GEN_D0;
            cost = '0;
            for (int j = 0; j < 7; j++) begin
                s    = soft_word[8*j +: 8];
                cost = cost + (cw[6-j] ? 11'(8'd255 - s) : 11'(s));
            end
            if (k == 0 || cost < best_cost) begin
                best      = cand;
                best_cost = cost;
            end
        end
        return best;
    endfunction

    always @(posedge i_clk) begin : watch
        logic [3:0] sym;
        t_byte_exp  want;
        t_byte_exp  got;
        if (!i_rst_n) begin
            byte_q.delete();
            first_nibble = '0;
            have_nibble  = 1'b0;
            fail_total   = 0;
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                got.dec_byte   = i_m_tdata;
                got.final_byte = i_m_tlast;
                if (byte_q.size() == 0) begin
                    fail_total = fail_total + 1;
                    if (fail_total <= 10)
                        $display("unexpected byte %h last %b", got.dec_byte, got.final_byte);
                end else begin
                    want = byte_q.pop_front();
                    if (got != want) begin
                        fail_total = fail_total + 1;
                        if (fail_total <= 10)
                            $display("mismatch: expected byte %h last %b, got byte %h last %b",
                                     want.dec_byte, want.final_byte,
                                     got.dec_byte, got.final_byte);
                    end
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                sym = ml_symbol(i_s_tdata);
                if (have_nibble) begin
                    want.dec_byte   = {first_nibble, sym};
                    want.final_byte = i_s_tlast;
                    byte_q.push_back(want);
                    have_nibble  = 1'b0;
                    first_nibble = '0;
                end else if (i_s_tlast) begin
                    // odd message: close the byte with a zero low nibble
                    want.dec_byte   = {sym, 4'h0};
                    want.final_byte = 1'b1;
                    byte_q.push_back(want);
                    first_nibble = '0;
                end else begin
                    first_nibble = sym;
                    have_nibble  = 1'b1;
                end
            end
        end
        o_fail_count <= fail_total;
        o_pending    <= byte_q.size();
    end

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps

module tb;

    localparam int IDLE_LIMIT = 5000;
    localparam int PHASE_ITEMS = 163;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [55:0] s_axis_tdata = '0;  // soft_bit_0, soft_bit_1, .. soft_bit_6
    logic        s_axis_tlast = 1'b0;  // final_codeword
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;  // decoded_byte
    logic        m_axis_tlast;  // final_byte

    int fail_count;
    int pending_bytes;
    int send_pct = 0;
    int stall_pct = 0;
    int idle_cycles = 0;

    hamming74_soft_decision_decoder dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    hsd_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (s_axis_tvalid),
        .i_s_tready   (s_axis_tready),
        .i_s_tdata    (s_axis_tdata),
        .i_s_tlast    (s_axis_tlast),
        .i_m_tvalid   (m_axis_tvalid),
        .i_m_tready   (m_axis_tready),
        .i_m_tdata    (m_axis_tdata),
        .i_m_tlast    (m_axis_tlast),
        .o_fail_count (fail_count),
        .o_pending    (pending_bytes)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("FAIL");
                $finish;
            end
        end
    end

    function automatic logic [55:0] noisy_word(input logic [3:0] sym, input int noise_max,
                                               input int flip_pct);
        logic [6:0]  cw;
        logic [55:0] w;
        logic        b;
        int          n;
        cw = '0;
        if (sym[3]) cw = cw ^ hsd_pkg::GEN_D3;
        if (sym[2]) cw = cw ^ hsd_pkg::GEN_D2;
        if (sym[1]) cw = cw ^ hsd_pkg::GEN_D1;
        if (sym[0]) cw = cw ^ hsd_pkg::GEN_D0;
        for (int j = 0; j < 7; j++) begin
            n = $urandom_range(0, noise_max);
            b = cw[6-j] ^ ($urandom_range(0, 99) < flip_pct);
            w[8*j +: 8] = b ? 8'(255 - n) : 8'(n);
        end
        return w;
    endfunction

    task automatic send_codeword(input logic [55:0] soft_word, input logic fin);
        logic ok;
        while ($urandom_range(0, 99) < send_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= soft_word;
        s_axis_tlast  <= fin;
        do begin
            @(negedge i_clk);
            ok = s_axis_tready;
            @(posedge i_clk);
        end while (!ok);
    endtask

    // hold off until every expected byte is out, then switch idling
    task automatic drain_and_set(input int next_send, input int next_stall);
        s_axis_tvalid <= 1'b0;
        @(negedge i_clk);
        while (pending_bytes != 0) @(negedge i_clk);
        send_pct  = next_send;
        stall_pct = next_stall;
        @(posedge i_clk);
    endtask

    task automatic random_phase(input int count);
        logic [55:0] w;
        int          r;
        for (int i = 0; i < count; i++) begin
            r = $urandom_range(0, 99);
            if (r < 70) begin
                w = noisy_word(4'($urandom_range(0, 15)), $urandom_range(0, 120), 5);
            end else if (r < 85) begin
                w = 56'({$urandom(), $urandom()});
            end else begin
                for (int j = 0; j < 7; j++) w[8*j +: 8] = 8'($urandom_range(120, 135));
            end
            send_codeword(w, $urandom_range(0, 9) == 0);
        end
    endtask

    initial begin : stimulus
        logic [55:0] tie_word;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_codeword('0, 1'b0);
        send_codeword({56{1'b1}}, 1'b0);
        for (int k = 0; k < 16; k++) send_codeword(noisy_word(4'(k), 0, 0), k == 15);
        // tie between symbol 0 and symbol 1; final mark on a first codeword
        tie_word = '0;
        tie_word[0*8 +: 8] = 8'd127;
        tie_word[1*8 +: 8] = 8'd128;
        tie_word[3*8 +: 8] = 8'd127;
        tie_word[6*8 +: 8] = 8'd128;
        send_codeword(tie_word, 1'b1);
        send_codeword({7{8'h80}}, 1'b0);
        send_codeword({7{8'h7f}}, 1'b1);
        send_codeword(56'({$urandom(), $urandom()}), 1'b1);
        drain_and_set(0, 0);

        random_phase(PHASE_ITEMS);
        drain_and_set(64, 0);
        random_phase(PHASE_ITEMS);
        drain_and_set(0, 64);
        random_phase(PHASE_ITEMS);
        drain_and_set(12, 12);
        random_phase(PHASE_ITEMS);
        drain_and_set(0, 0);

        repeat (10) @(posedge i_clk);
        if (fail_count == 0 && pending_bytes == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
